// ===== design/scdec_pkg.sv =====
package scdec_pkg;

  // Ring store geometry
  localparam int unsigned Depth = 512;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Scan code set 1 constants
  localparam logic [7:0] PrefixCode  = 8'hE0;
  localparam logic [7:0] LShiftMake  = 8'h2A;
  localparam logic [7:0] RShiftMake  = 8'h36;
  localparam logic [7:0] LShiftBreak = 8'hAA;
  localparam logic [7:0] RShiftBreak = 8'hB6;
  localparam logic [7:0] CapsMake    = 8'h3A;
  localparam logic [6:0] CaseOffset  = 7'd32;

  // Request from the decode front to the buffer back end
  typedef struct packed {
    logic       is_read;
    logic [6:0] ch;
  } req_t;

  function automatic logic [6:0] plain_char(input logic [7:0] code);
    logic [6:0] c;
    case (code)
      8'd2:  c = 7'h31;
      8'd3:  c = 7'h32;
      8'd4:  c = 7'h33;
      8'd5:  c = 7'h34;
      8'd6:  c = 7'h35;
      8'd7:  c = 7'h36;
      8'd8:  c = 7'h37;
      8'd9:  c = 7'h38;
      8'd10: c = 7'h39;
      8'd11: c = 7'h30;
      8'd12: c = 7'h2D;
      8'd13: c = 7'h3D;
      8'd14: c = 7'h08;
      8'd16: c = 7'h71;
      8'd17: c = 7'h77;
      8'd18: c = 7'h65;
      8'd19: c = 7'h72;
      8'd20: c = 7'h74;
      8'd21: c = 7'h79;
      8'd22: c = 7'h75;
      8'd23: c = 7'h69;
      8'd24: c = 7'h6F;
      8'd25: c = 7'h70;
      8'd26: c = 7'h5B;
      8'd27: c = 7'h5D;
      8'd28: c = 7'h0A;
      8'd30: c = 7'h61;
      8'd31: c = 7'h73;
      8'd32: c = 7'h64;
      8'd33: c = 7'h66;
      8'd34: c = 7'h67;
      8'd35: c = 7'h68;
      8'd36: c = 7'h6A;
      8'd37: c = 7'h6B;
      8'd38: c = 7'h6C;
      8'd39: c = 7'h3B;
      8'd40: c = 7'h27;
      8'd41: c = 7'h60;
      8'd43: c = 7'h5C;
      8'd44: c = 7'h7A;
      8'd45: c = 7'h78;
      8'd46: c = 7'h63;
      8'd47: c = 7'h76;
      8'd48: c = 7'h62;
      8'd49: c = 7'h6E;
      8'd50: c = 7'h6D;
      8'd51: c = 7'h2C;
      8'd52: c = 7'h2E;
      8'd53: c = 7'h2F;
      8'd55: c = 7'h2A;
      8'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [7:0] code);
    logic [6:0] c;
    case (code)
      8'd1:  c = 7'h01;
      8'd2:  c = 7'h21;
      8'd3:  c = 7'h40;
      8'd4:  c = 7'h23;
      8'd5:  c = 7'h24;
      8'd6:  c = 7'h25;
      8'd7:  c = 7'h5E;
      8'd8:  c = 7'h26;
      8'd9:  c = 7'h2A;
      8'd10: c = 7'h28;
      8'd11: c = 7'h29;
      8'd12: c = 7'h5F;
      8'd13: c = 7'h2B;
      8'd14: c = 7'h08;
      8'd15: c = 7'h09;
      8'd16: c = 7'h51;
      8'd17: c = 7'h57;
      8'd18: c = 7'h45;
      8'd19: c = 7'h52;
      8'd20: c = 7'h54;
      8'd21: c = 7'h59;
      8'd22: c = 7'h55;
      8'd23: c = 7'h49;
      8'd24: c = 7'h4F;
      8'd25: c = 7'h50;
      8'd26: c = 7'h7B;
      8'd27: c = 7'h7D;
      8'd28: c = 7'h0A;
      8'd30: c = 7'h41;
      8'd31: c = 7'h53;
      8'd32: c = 7'h44;
      8'd33: c = 7'h46;
      8'd34: c = 7'h47;
      8'd35: c = 7'h48;
      8'd36: c = 7'h4A;
      8'd37: c = 7'h4B;
      8'd38: c = 7'h4C;
      8'd39: c = 7'h3A;
      8'd40: c = 7'h22;
      8'd41: c = 7'h7E;
      8'd43: c = 7'h7C;
      8'd44: c = 7'h5A;
      8'd45: c = 7'h58;
      8'd46: c = 7'h43;
      8'd47: c = 7'h56;
      8'd48: c = 7'h42;
      8'd49: c = 7'h4E;
      8'd50: c = 7'h4D;
      8'd51: c = 7'h3C;
      8'd52: c = 7'h3E;
      8'd53: c = 7'h3F;
      8'd55: c = 7'h2A;
      8'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(Depth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

endpackage

// ===== design/scdec_front.sv =====
module scdec_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               action_i,
  input  logic [7:0]         scan_byte_i,
  output scdec_pkg::req_t    req_o
);
  import scdec_pkg::*;

  logic prefix_q, prefix_d;
  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic [6:0] raw_ch, ch;

  always_comb begin
    prefix_d = prefix_q;
    shift_d  = shift_q;
    caps_d   = caps_q;
    raw_ch   = 7'h00;
    ch       = 7'h00;
    if (scan_byte_i == PrefixCode) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
    end else if (scan_byte_i[7]) begin
      if (scan_byte_i == LShiftBreak || scan_byte_i == RShiftBreak) begin
        shift_d = 1'b0;
      end
    end else begin
      if (scan_byte_i == LShiftMake || scan_byte_i == RShiftMake) begin
        shift_d = 1'b1;
      end
      if (scan_byte_i == CapsMake) begin
        caps_d = ~caps_q;
      end
      raw_ch = shift_d ? shifted_char(scan_byte_i) : plain_char(scan_byte_i);
      ch     = raw_ch;
      // Flip letter case while caps lock is on
      if (caps_d) begin
        if (raw_ch >= 7'h61 && raw_ch <= 7'h7A) begin
          ch = raw_ch - CaseOffset;
        end else if (raw_ch >= 7'h41 && raw_ch <= 7'h5A) begin
          ch = raw_ch + CaseOffset;
        end
      end
    end
  end

  assign req_o.is_read = action_i;
  assign req_o.ch      = action_i ? 7'h00 : ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
    end else if (accept_i && !action_i) begin
      prefix_q <= prefix_d;
      shift_q  <= shift_d;
      caps_q   <= caps_d;
    end
  end

endmodule

// ===== design/scdec_queue.sv =====
module scdec_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scdec_pkg::req_t push_req_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output scdec_pkg::req_t pop_req_o
);
  import scdec_pkg::*;

  req_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_req_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/scdec_back.sv =====
module scdec_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  scdec_pkg::req_t req_i,
  output logic            req_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      key_char_o,
  output logic            char_valid_o,
  output logic            dropped_o
);
  import scdec_pkg::*;

  logic [6:0]      mem [Depth];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic            issue, empty, full, do_push, do_pop;

  logic       out_valid_q;
  logic       out_pop_q;
  logic [6:0] out_ch_q;
  logic       out_cv_q;
  logic       out_drop_q;
  logic [6:0] rdata_q;

  assign issue     = req_valid_i && (!out_valid_q || out_ready_i);
  assign req_pop_o = issue;
  assign empty     = (rd_ptr_q == wr_ptr_q);
  assign full      = (next_slot(wr_ptr_q) == rd_ptr_q);
  assign do_push   = issue && !req_i.is_read && (req_i.ch != 7'h00) && !full;
  assign do_pop    = issue && req_i.is_read && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= req_i.ch;
    end
    if (do_pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
    if (issue) begin
      out_ch_q   <= req_i.ch;
      out_cv_q   <= !req_i.is_read && (req_i.ch != 7'h00);
      out_drop_q <= !req_i.is_read && (req_i.ch != 7'h00) && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
      out_pop_q   <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_slot(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_slot(rd_ptr_q);
      end
      if (issue) begin
        out_valid_q <= 1'b1;
        out_pop_q   <= do_pop;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_char_o   = out_pop_q ? rdata_q : out_ch_q;
  assign char_valid_o = out_pop_q ? (rdata_q != 7'h00) : out_cv_q;
  assign dropped_o    = out_pop_q ? 1'b0 : out_drop_q;

endmodule

// ===== design/scan_code_set1_key_decoder_fifo.sv =====
// Scan code set 1 keyboard decoder with a buffer of typed characters.
// Input channel (in_valid_i / in_ready_o) carries one request per item:
// action_i = 0 delivers a raw scan code byte in scan_byte_i, action_i = 1
// asks to pop the oldest buffered character.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// request: key_char_o, char_valid_o and dropped_o. A decoded byte reports its
// character (a drop is flagged when the 511-entry buffer is full); a pop
// reports the oldest character, or all zeros when the buffer is empty.
// From acceptance the request is written into the two-entry queue behind
// the decoder and is then issued into the output register, which also holds
// the registered read of the RAM. Throughput is one request per cycle while
// the receiver keeps out_ready_i high; the character RAM takes one write
// or one read each cycle, which sets that rate.
// Reset clears the prefix, shift and caps lock flags, both buffer pointers
// and all handshake state; the RAM contents are not cleared.
// While the receiver stalls, the result holds in the output register, the
// queue fills, and in_ready_o drops once both queue entries are taken; it
// rises again in the cycle after the held result is taken.
module scan_code_set1_key_decoder_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] key_char_o,
  output logic       char_valid_o,
  output logic       dropped_o
);
  import scdec_pkg::*;

  req_t front_req;
  req_t back_req;
  logic accept;
  logic q_full, q_valid, q_pop;

  // Accept while the request queue has room
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Decode bytes and track prefix, shift and caps lock state
  scdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .scan_byte_i (scan_byte_i),
    .req_o       (front_req)
  );

  // Decouple the decoder from the buffer stage
  scdec_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_req_i (front_req),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_req_o  (back_req)
  );

  // Buffer characters, service reads and hold the result
  scdec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (q_valid),
    .req_i        (back_req),
    .req_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_char_o   (key_char_o),
    .char_valid_o (char_valid_o),
    .dropped_o    (dropped_o)
  );

endmodule
